/* src/hta_pkg.sv */
// Package for the handle table allocator: command and status codes and the
// item type that passes from the front end to the back end. No dependencies.
`default_nettype none
package hta_pkg;
  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_RESIZE = 3'd2;
  localparam logic [2:0] CMD_QUERY  = 3'd3;
  localparam logic [2:0] CMD_LOCK   = 3'd4;
  localparam logic [2:0] CMD_UNLOCK = 3'd5;
  localparam logic [2:0] CMD_ACCESS = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_LOCKED     = 3'd3;
  localparam logic [2:0] ST_NOT_LOCKED = 3'd4;
  localparam logic [2:0] ST_LOCK_OVF   = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  slot;
    logic [31:0] tag;
    logic [31:0] amount;
  } hta_item_t;
endpackage
`default_nettype wire

/* src/handle_table_allocator.sv */
// Top level of the handle table allocator: a front end, a two-entry queue and
// the back end. Depends on hta_pkg, hta_fifo and hta_back.
//
// Usage: commands enter on the in_ channel (valid/ready) and each gives
// exactly one result on the out_ channel (valid/ready). The front end
// registers each item and pushes it into a two-entry queue, so the input
// keeps accepting while the back end works or the receiver stalls, until
// the queue and the front register are full. The back end works on one item
// at a time. A handle command passes through the back end in steps: slot
// RAM read, execute and write back, result. An alloc steps its free-slot
// search one slot per cycle from the last slot allocated, up to SLOTS slots.
// The result register holds its item until out_ready is seen, and the back
// end waits meanwhile. Reset empties the queue, marks every slot free, sets
// the next tag to one and clears the totals; no clearing pass is needed.
`default_nettype none
module handle_table_allocator
  import hta_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int LOCK_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [7:0]  in_handle_slot,
  input  wire logic [31:0] in_handle_tag,
  input  wire logic [31:0] in_amount,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot,
  output logic [31:0]      out_tag,
  output logic [31:0]      out_length,
  output logic             out_is_locked,
  output logic [39:0]      out_bytes_in_use,
  output logic [8:0]       out_slots_in_use
);
  hta_item_t fr_item_r;
  logic      fr_valid_r;
  logic      q_ready, b_valid, b_ready;
  hta_item_t b_item;

  assign in_ready = !fr_valid_r || q_ready;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item_r <= '{cmd: in_cmd, slot: in_handle_slot, tag: in_handle_tag,
                     amount: in_amount};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_ready) begin
      fr_valid_r <= in_valid;
    end
  end

  hta_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fr_valid_r), .wr_ready(q_ready), .wr_item(fr_item_r),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item));

  hta_back #(.SLOTS(SLOTS), .LOCK_BITS(LOCK_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot(out_slot), .out_tag(out_tag),
    .out_length(out_length), .out_is_locked(out_is_locked),
    .out_bytes_in_use(out_bytes_in_use), .out_slots_in_use(out_slots_in_use));
endmodule
`default_nettype wire

/* src/hta_ram.sv */
// Generic single-port RAM with registered read data. No dependencies.
`default_nettype none
module hta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* src/hta_fifo.sv */
// Two-entry queue of decoded items between front end and back end.
// Depends on hta_pkg.
`default_nettype none
module hta_fifo
  import hta_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  hta_item_t      wr_item,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output hta_item_t      rd_item
);
  hta_item_t  buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      buf_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp_r <= ~wp_r;
      end
      if (rd_valid && rd_ready) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule
`default_nettype wire

/* src/hta_back.sv */
// Back end: executes one item at a time against the slot RAMs, runs the
// rotating free-slot search and keeps the totals. Depends on hta_pkg, hta_ram.
`default_nettype none
module hta_back
  import hta_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int LOCK_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  hta_item_t        in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot,
  output logic [31:0]      out_tag,
  output logic [31:0]      out_length,
  output logic             out_is_locked,
  output logic [39:0]      out_bytes_in_use,
  output logic [8:0]       out_slots_in_use
);
  localparam int AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  hta_item_t    item_r;
  logic [SLOTS-1:0] used_r;
  logic [31:0]  next_tag_r;
  logic [AW-1:0] start_r, scan_r;
  logic [AW:0]  scan_cnt_r;
  logic [39:0]  total_bytes_r;
  logic [8:0]   total_slots_r;

  logic         we;
  logic [AW-1:0] addr;
  logic [31:0]  len_w, tag_w, len_q, tag_q;
  logic [LOCK_BITS-1:0] lk_w, lk_q;

  hta_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_len (
    .clk(clk), .we(we), .addr(addr), .wdata(len_w), .rdata(len_q));
  hta_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tag (
    .clk(clk), .we(we), .addr(addr), .wdata(tag_w), .rdata(tag_q));
  hta_ram #(.WIDTH(LOCK_BITS), .DEPTH(SLOTS)) u_lock (
    .clk(clk), .we(we), .addr(addr), .wdata(lk_w), .rdata(lk_q));

  logic hs_in_range, valid_h, lk_zero, lk_max;
  logic [AW-1:0] hs;
  always_comb begin
    hs = AW'(item_r.slot);
    hs_in_range = ({24'd0, item_r.slot} < 32'(SLOTS));
    valid_h = hs_in_range && (item_r.tag != 32'd0) && used_r[hs] && (tag_q == item_r.tag);
    lk_zero = (lk_q == '0);
    lk_max = (lk_q == {LOCK_BITS{1'b1}});
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = (in_item.cmd == CMD_ALLOC) ? S_SRCH : S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_SRCH: if (!used_r[scan_r] || scan_cnt_r == AW'(0) + (AW+1)'(SLOTS - 1))
                state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    addr = hs;
    len_w = item_r.amount;
    tag_w = next_tag_r;
    lk_w = '0;
    if (state_r == S_IDLE) begin
      addr = AW'(in_item.slot);
    end else if (state_r == S_SRCH) begin
      addr = scan_r;
      we = !used_r[scan_r];
    end else if (state_r == S_EXEC && valid_h) begin
      tag_w = tag_q;
      len_w = len_q;
      lk_w = lk_q;
      case (item_r.cmd)
        CMD_RESIZE: if (lk_zero) begin
          we = 1'b1;
          len_w = item_r.amount;
        end
        CMD_LOCK: if (!lk_max) begin
          we = 1'b1;
          lk_w = lk_q + 1'b1;
        end
        CMD_UNLOCK: if (!lk_zero) begin
          we = 1'b1;
          lk_w = lk_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_bytes_in_use = total_bytes_r;
  assign out_slots_in_use = total_slots_r;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_item;
    end
    if (state_r == S_SRCH) begin
      scan_r <= (scan_r == LAST) ? '0 : scan_r + 1'b1;
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end else begin
      scan_r <= start_r;
      scan_cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      next_tag_r <= 32'd1;
      start_r <= '0;
      total_bytes_r <= '0;
      total_slots_r <= '0;
      out_status <= ST_OK;
      out_slot <= '0;
      out_tag <= '0;
      out_length <= '0;
      out_is_locked <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        out_status <= ST_INVALID;
        out_slot <= '0;
        out_tag <= '0;
        out_length <= '0;
        out_is_locked <= 1'b0;
      end
      if (state_r == S_SRCH) begin
        if (!used_r[scan_r]) begin
          used_r[scan_r] <= 1'b1;
          start_r <= scan_r;
          next_tag_r <= (next_tag_r == 32'hFFFF_FFFF) ? 32'd1 : next_tag_r + 1'b1;
          total_bytes_r <= total_bytes_r + {8'd0, item_r.amount};
          total_slots_r <= total_slots_r + 1'b1;
          out_status <= ST_OK;
          out_slot <= 8'(scan_r);
          out_tag <= next_tag_r;
          out_length <= item_r.amount;
        end else if (state_nxt == S_OUT) begin
          out_status <= ST_FULL;
        end
      end
      if (state_r == S_EXEC && valid_h) begin
        out_status <= ST_OK;
        out_length <= len_q;
        out_is_locked <= !lk_zero;
        case (item_r.cmd)
          CMD_FREE: begin
            if (!lk_zero) begin
              out_status <= ST_LOCKED;
            end else begin
              used_r[hs] <= 1'b0;
              total_bytes_r <= total_bytes_r - {8'd0, len_q};
              total_slots_r <= total_slots_r - 1'b1;
              out_length <= '0;
            end
          end
          CMD_RESIZE: begin
            if (!lk_zero) begin
              out_status <= ST_LOCKED;
            end else begin
              total_bytes_r <= total_bytes_r - {8'd0, len_q} + {8'd0, item_r.amount};
              out_length <= item_r.amount;
            end
          end
          CMD_LOCK: begin
            if (lk_max) out_status <= ST_LOCK_OVF;
            else out_is_locked <= 1'b1;
          end
          CMD_UNLOCK: begin
            if (lk_zero) out_status <= ST_NOT_LOCKED;
            else out_is_locked <= (lk_q != {{(LOCK_BITS-1){1'b0}}, 1'b1});
          end
          CMD_ACCESS: if (lk_zero) out_status <= ST_NOT_LOCKED;
          CMD_QUERY: ;
          default: begin
            out_status <= ST_INVALID;
            out_length <= '0;
            out_is_locked <= 1'b0;
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

/* sim/hta_checker.sv */
// Checker for the handle table allocator: watches both channels, predicts each
// result from its own copy of the slot table and compares. Depends on hta_pkg.
`default_nettype none
module hta_checker
  import hta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [7:0]  in_handle_slot,
  input  wire logic [31:0] in_handle_tag,
  input  wire logic [31:0] in_amount,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_status,
  input  wire logic [7:0]  out_slot,
  input  wire logic [31:0] out_tag,
  input  wire logic [31:0] out_length,
  input  wire logic        out_is_locked,
  input  wire logic [39:0] out_bytes_in_use,
  input  wire logic [8:0]  out_slots_in_use,
  output int               fail_count,
  output int               outstanding
);
  localparam int NSLOTS = 256;
  localparam int unsigned LOCK_MAX = (1 << 16) - 1;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] tag;
    logic [31:0] length;
    logic        locked;
    logic [39:0] bytes;
    logic [8:0]  slots;
  } hta_result_t;

  bit          used_r [NSLOTS];
  logic [31:0] len_r  [NSLOTS];
  logic [31:0] tag_r  [NSLOTS];
  int unsigned lock_r [NSLOTS];
  logic [31:0] next_tag;
  logic [7:0]  search_start;
  logic [39:0] tot_bytes;
  logic [8:0]  tot_slots;
  hta_result_t expected_results[$];

  function automatic hta_result_t table_outcome(logic [2:0] cmd, logic [7:0] hs,
                                                logic [31:0] ht, logic [31:0] amt);
    hta_result_t r;
    bit found;
    bit report;
    int s;
    int idx;
    r = '0;
    r.status = ST_INVALID;
    found = 0;
    report = 0;
    s = 0;
    if (cmd == CMD_ALLOC) begin
      for (int i = 0; i < NSLOTS && !found; i++) begin
        idx = (int'(search_start) + i) % NSLOTS;
        if (!used_r[idx]) begin
          s = idx;
          found = 1;
        end
      end
      if (!found) begin
        r.status = ST_FULL;
      end else begin
        search_start = s[7:0];
        used_r[s] = 1;
        len_r[s] = amt;
        tag_r[s] = next_tag;
        lock_r[s] = 0;
        next_tag = next_tag + 32'd1;
        if (next_tag == 32'd0) next_tag = 32'd1;
        tot_bytes = tot_bytes + {8'd0, amt};
        tot_slots = tot_slots + 9'd1;
        r.slot = s[7:0];
        r.tag = tag_r[s];
        r.status = ST_OK;
        report = 1;
      end
    end else if (cmd != CMD_UNUSED && ht != 32'd0 && used_r[hs] && tag_r[hs] == ht) begin
      s = int'(hs);
      report = 1;
      r.status = ST_OK;
      case (cmd)
        CMD_FREE: begin
          if (lock_r[s] != 0) begin
            r.status = ST_LOCKED;
          end else begin
            tot_bytes = tot_bytes - {8'd0, len_r[s]};
            tot_slots = tot_slots - 9'd1;
            used_r[s] = 0;
            len_r[s] = 0;
            tag_r[s] = 0;
            lock_r[s] = 0;
          end
        end
        CMD_RESIZE: begin
          if (lock_r[s] != 0) begin
            r.status = ST_LOCKED;
          end else begin
            tot_bytes = tot_bytes - {8'd0, len_r[s]} + {8'd0, amt};
            len_r[s] = amt;
          end
        end
        CMD_LOCK: begin
          if (lock_r[s] >= LOCK_MAX) r.status = ST_LOCK_OVF;
          else lock_r[s] = lock_r[s] + 1;
        end
        CMD_UNLOCK: begin
          if (lock_r[s] == 0) r.status = ST_NOT_LOCKED;
          else lock_r[s] = lock_r[s] - 1;
        end
        CMD_ACCESS: begin
          if (lock_r[s] == 0) r.status = ST_NOT_LOCKED;
        end
        default: begin
        end
      endcase
    end
    if (report && used_r[s]) begin
      r.length = len_r[s];
      r.locked = (lock_r[s] != 0);
    end
    r.bytes = tot_bytes;
    r.slots = tot_slots;
    return r;
  endfunction

  hta_result_t got;
  hta_result_t want;

  assign outstanding = expected_results.size();
  assign got = '{out_status, out_slot, out_tag, out_length, out_is_locked,
                 out_bytes_in_use, out_slots_in_use};

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOTS; i++) begin
        used_r[i] = 0;
        len_r[i] = 0;
        tag_r[i] = 0;
        lock_r[i] = 0;
      end
      next_tag = 1;
      search_start = 0;
      tot_bytes = 0;
      tot_slots = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d slot %0d tag %h", $time,
                   out_status, out_slot, out_tag);
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected status %0d slot %0d tag %h len %h lk %0d",
                     $time, want.status, want.slot, want.tag, want.length, want.locked);
            $display("%0t:   bytes %h slots %0d; actual status %0d slot %0d tag %h",
                     $time, want.bytes, want.slots, got.status, got.slot, got.tag);
            $display("%0t:   len %h lk %0d bytes %h slots %0d", $time, got.length,
                     got.locked, got.bytes, got.slots);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(table_outcome(in_cmd, in_handle_slot,
                                                 in_handle_tag, in_amount));
    end
  end
endmodule
`default_nettype wire

/* sim/handle_table_allocator_tb.sv */
// Testbench top for the handle table allocator: clock, reset, directed and
// random command stimulus, verdict. Depends on hta_pkg, hta_checker and the block.
`default_nettype none
module handle_table_allocator_tb
  import hta_pkg::*;
;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_cmd;
  logic [7:0]  in_handle_slot;
  logic [31:0] in_handle_tag;
  logic [31:0] in_amount;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_slot;
  logic [31:0] out_tag;
  logic [31:0] out_length;
  logic        out_is_locked;
  logic [39:0] out_bytes_in_use;
  logic [8:0]  out_slots_in_use;
  int          fail_count;
  int          outstanding;

  int          idle_pct;
  int          stall_pct;
  int          quiet_cycles;
  logic [2:0]  sent_cmds[$];
  logic [7:0]  live_slot[$];
  logic [31:0] live_tag[$];

  handle_table_allocator dut (.*);
  hta_checker u_checker (.*);

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_cmd = 0;
    in_handle_slot = 0;
    in_handle_tag = 0;
    in_amount = 0;
    out_ready = 0;
    idle_pct = 0;
    stall_pct = 0;
  end

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Tracks live handles from the results so that stimulus can reuse them.
  always @(posedge clk) begin
    logic [2:0] c;
    if (in_valid && in_ready) quiet_cycles <= 0;
    else if (out_valid && out_ready) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_valid && out_ready && sent_cmds.size() > 0) begin
      c = sent_cmds.pop_front();
      if (c == CMD_ALLOC && out_status == ST_OK) begin
        live_slot.push_back(out_slot);
        live_tag.push_back(out_tag);
      end
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial quiet_cycles = 0;

  task automatic send_cmd(logic [2:0] c, logic [7:0] hs, logic [31:0] ht,
                          logic [31:0] amt);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1;
    in_cmd <= c;
    in_handle_slot <= hs;
    in_handle_tag <= ht;
    in_amount <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cmds.push_back(c);
    if (c == CMD_FREE) begin
      for (int i = 0; i < live_slot.size(); i++) begin
        if (live_slot[i] == hs && live_tag[i] == ht && $urandom_range(0, 3) != 0) begin
          live_slot.delete(i);
          live_tag.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic random_cmd();
    int k;
    int pick;
    logic [31:0] amt;
    logic [2:0] c;
    k = $urandom_range(0, 99);
    amt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4095);
    if (k < 20 || live_slot.size() == 0) begin
      send_cmd(CMD_ALLOC, 8'($urandom()), $urandom(), amt);
    end else if (k < 85) begin
      pick = $urandom_range(0, live_slot.size() - 1);
      if (live_slot.size() > 200 && $urandom_range(0, 1) == 0) c = CMD_FREE;
      else c = 3'($urandom_range(1, 6));
      send_cmd(c, live_slot[pick], live_tag[pick], amt);
    end else begin
      pick = $urandom_range(0, live_slot.size() - 1);
      case ($urandom_range(0, 3))
        0: send_cmd(3'($urandom_range(1, 7)), 8'($urandom()), $urandom(), $urandom());
        1: send_cmd(3'($urandom_range(1, 6)), live_slot[pick], 32'd0, amt);
        2: send_cmd(CMD_UNUSED, live_slot[pick], live_tag[pick], amt);
        default: send_cmd(3'($urandom_range(1, 6)), live_slot[pick],
                          live_tag[pick] ^ (32'd1 << $urandom_range(0, 31)), amt);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // After reset the first allocs land in slot 0 with tag 1 and slot 1 with tag 2.
    send_cmd(CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF, 32'd0);
    send_cmd(CMD_ALLOC, 8'h00, 32'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_QUERY, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_QUERY, 8'd1, 32'd2, 32'd0);
    send_cmd(CMD_QUERY, 8'd1, 32'd0, 32'd0);
    send_cmd(CMD_QUERY, 8'd0, 32'd2, 32'd0);
    send_cmd(CMD_QUERY, 8'd200, 32'd1, 32'd0);
    send_cmd(CMD_UNUSED, 8'd0, 32'd1, 32'd5);
    send_cmd(CMD_RESIZE, 8'd1, 32'd2, 32'hFFFF_FFFF);
    send_cmd(CMD_RESIZE, 8'd0, 32'd1, 32'd1234);
    send_cmd(CMD_ACCESS, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_UNLOCK, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_LOCK, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_FREE, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_RESIZE, 8'd0, 32'd1, 32'd7);
    send_cmd(CMD_ACCESS, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_UNLOCK, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_FREE, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_QUERY, 8'd0, 32'd1, 32'd0);
    send_cmd(CMD_FREE, 8'd0, 32'd1, 32'd0);

    // Lock slot 1 several times, show that free is refused, then release it.
    for (int i = 0; i < 20; i++) send_cmd(CMD_LOCK, 8'd1, 32'd2, 32'd0);
    send_cmd(CMD_FREE, 8'd1, 32'd2, 32'd0);
    for (int i = 0; i < 20; i++) send_cmd(CMD_UNLOCK, 8'd1, 32'd2, 32'd0);
    send_cmd(CMD_FREE, 8'd1, 32'd2, 32'd0);

    // Fill the table until alloc reports it full.
    for (int i = 0; i < 258; i++) send_cmd(CMD_ALLOC, 8'($urandom()), $urandom(), $urandom());

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (int i = 0; i < 270; i++) random_cmd();
    end

    @(negedge clk);
    in_valid <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
